// ----- hdl/toy_cpu_execute_unit_defines.svh -----
// Assertion macros shared by the checker of the execute unit.
// Depends on nothing; included by the checker file.
`ifndef TOY_CPU_EXECUTE_UNIT_DEFINES_SVH
`define TOY_CPU_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TCPU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TCPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/tcpu_pkg.sv -----
// Shared types, codes and constants of the execute unit.
// Depends on nothing; used by every module of the unit.
package tcpu_pkg;

	localparam int DATA_WORDS_DEF = 4096;
	localparam int NUM_REGS       = 9;
	localparam int DIV_STEPS      = 32;
	localparam logic [15:0] DEFAULT_BASE = 16'd16384;

	localparam logic [3:0] OP_STOP = 4'd0;
	localparam logic [3:0] OP_MOV  = 4'd1;
	localparam logic [3:0] OP_ADD  = 4'd2;
	localparam logic [3:0] OP_SUB  = 4'd3;
	localparam logic [3:0] OP_MUL  = 4'd4;
	localparam logic [3:0] OP_DIV  = 4'd5;
	localparam logic [3:0] OP_AND  = 4'd6;
	localparam logic [3:0] OP_OR   = 4'd7;
	localparam logic [3:0] OP_NOT  = 4'd8;
	localparam logic [3:0] OP_CMP  = 4'd9;
	localparam logic [3:0] OP_JMP  = 4'd10;
	localparam logic [3:0] OP_IN   = 4'd11;
	localparam logic [3:0] OP_OUT  = 4'd12;

	localparam logic [3:0] JC_ALWAYS = 4'd0;
	localparam logic [3:0] JC_EQ     = 4'd1;
	localparam logic [3:0] JC_GT     = 4'd2;
	localparam logic [3:0] JC_LT     = 4'd3;

	localparam logic [1:0] FLAG_EQ = 2'b00;
	localparam logic [1:0] FLAG_GT = 2'b01;
	localparam logic [1:0] FLAG_LT = 2'b11;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_DIV0 = 2'd1;
	localparam logic [1:0] ERR_ADDR = 2'd2;

	typedef struct packed {
		logic accept;
		logic read_b;
		logic calc_addr;
		logic mem_read;
		logic exec;
		logic div_step;
		logic div_wb;
		logic out_load;
		logic clr;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_go;
		logic res_free;
	} status_t;

endpackage

// ----- hdl/tcpu_ctrl.sv -----
// Controller state machine of the execute unit.
// Depends on tcpu_pkg; drives the datapath through cmd_t and reads status_t.
module tcpu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  tcpu_pkg::status_t st,
	output tcpu_pkg::cmd_t    cmd
);
	import tcpu_pkg::*;

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_RDB   = 3'd2;
	localparam logic [2:0] S_ADDR  = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_EXEC  = 3'd5;
	localparam logic [2:0] S_DIV   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	localparam int CW = $clog2(DIV_STEPS);

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          divwb_q, divwb_d;

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		divwb_d = 1'b0;
		cmd     = '0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (item_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_RDB;
				end
			end
			S_RDB: begin
				cmd.read_b = 1'b1;
				state_d    = S_ADDR;
			end
			S_ADDR: begin
				cmd.calc_addr = 1'b1;
				state_d       = S_READ;
			end
			S_READ: begin
				cmd.mem_read = 1'b1;
				state_d      = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				cnt_d    = '0;
				state_d  = st.div_go ? S_DIV : S_DONE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_STEPS - 1)) begin
					divwb_d = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.div_wb = divwb_q;
				if (divwb_q) begin
					state_d = S_DONE;
				end else if (st.res_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_q   <= '0;
			divwb_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			divwb_q <= divwb_d;
		end
	end

endmodule

// ----- hdl/tcpu_dpath.sv -----
// Datapath of the execute unit: register file, data memory, divider and result register.
// Depends on tcpu_pkg; steered by the controller through cmd_t.
module tcpu_dpath #(
	parameter int DATA_WORDS = tcpu_pkg::DATA_WORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tcpu_pkg::cmd_t     cmd,
	output tcpu_pkg::status_t  st,
	input  logic [15:0]        data_base,
	input  logic [3:0]         opcode,
	input  logic [3:0]         first_reg,
	input  logic [3:0]         second_reg,
	input  logic signed [31:0] immediate,
	input  logic [15:0]        pc_in,
	input  logic signed [31:0] input_value,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [31:0] out_value,
	output logic               out_valid,
	output logic               halted,
	output logic [1:0]         error_code,
	output logic               branch_taken,
	output logic [15:0]        next_pc,
	output logic signed [1:0]  compare_result
);
	import tcpu_pkg::*;

	localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
	localparam logic [32:0] LIMIT = 33'(DATA_WORDS);

	logic [31:0] rf_q [NUM_REGS];
	logic [31:0] mem_q [DATA_WORDS];

	logic [3:0]  op_q, a_q, b_q;
	logic [31:0] imm_q, inv_q, x_q, y_q, rdata_q;
	logic [15:0] pc_q;
	logic [AW-1:0] addr_q, clr_cnt_q;
	logic        aok_q;
	logic [1:0]  flag_q;

	logic [31:0] quo_q, dsr_q;
	logic [32:0] rem_q;
	logic        neg_q;

	logic [31:0] t_val_q;
	logic        t_ov_q, t_halt_q, t_tk_q;
	logic [1:0]  t_err_q;
	logic [15:0] t_npc_q;

	logic        res_vld_q;

	// Single read port of the register file.
	logic [3:0]  rf_ra;
	logic [31:0] rf_rd;
	assign rf_ra = cmd.accept ? first_reg : b_q;
	assign rf_rd = (rf_ra < 4'(NUM_REGS)) ? rf_q[rf_ra] : 32'd0;

	// Address mapping: truncating halving of the signed distance from the base.
	logic [31:0] ar;
	logic [33:0] diff;
	logic [33:0] adj;
	logic [32:0] qa;
	logic        a_lo, a_hi, b_lo, b_hi;
	assign a_lo = (a_q >= 4'd1) && (a_q <= 4'd4);
	assign a_hi = (a_q >= 4'd5) && (a_q <= 4'd8);
	assign b_lo = (b_q >= 4'd1) && (b_q <= 4'd4);
	assign b_hi = (b_q >= 4'd5) && (b_q <= 4'd8);

	always_comb begin
		ar = y_q;
		if (op_q == OP_MOV && a_hi && b_lo) ar = x_q;
		else if (op_q == OP_NOT && b_q == 4'd0) ar = {31'd0, (x_q == 32'd0)};
	end

	assign diff = {{2{ar[31]}}, ar} - {18'd0, data_base};
	assign adj  = diff + {33'd0, diff[33]};
	assign qa   = adj[33:1];

	// Execution of the instruction.
	logic [31:0] val;
	logic [63:0] prod;
	logic        wr_en, mem_we, flag_we, div_go;
	logic [31:0] wr_data, mem_wd;
	logic [1:0]  err, flag_d;
	logic        taken;
	logic        nv;

	assign val  = (b_q == 4'd0) ? imm_q : rdata_q;
	assign prod = x_q * val;
	assign nv   = (x_q == 32'd0);

	always_comb begin
		wr_en   = 1'b0;
		wr_data = 32'd0;
		mem_we  = 1'b0;
		mem_wd  = 32'd0;
		flag_we = 1'b0;
		flag_d  = FLAG_EQ;
		div_go  = 1'b0;
		err     = ERR_NONE;
		taken   = 1'b0;
		unique case (op_q)
			OP_MOV: begin
				if (b_q == 4'd0) begin
					wr_en   = 1'b1;
					wr_data = imm_q;
				end else if (a_lo && b_hi) begin
					if (aok_q) begin
						wr_en   = 1'b1;
						wr_data = rdata_q;
					end else err = ERR_ADDR;
				end else if (a_hi && b_lo) begin
					if (aok_q) begin
						mem_we = 1'b1;
						mem_wd = y_q;
					end else err = ERR_ADDR;
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (!b_lo) begin
					if (b_q != 4'd0 && !aok_q) err = ERR_ADDR;
					else begin
						unique case (op_q)
							OP_ADD: begin
								wr_en   = 1'b1;
								wr_data = x_q + val;
							end
							OP_SUB: begin
								wr_en   = 1'b1;
								wr_data = x_q - val;
							end
							OP_MUL: begin
								wr_en   = 1'b1;
								wr_data = prod[31:0];
							end
							default: begin
								if (val == 32'd0) err = ERR_DIV0;
								else div_go = 1'b1;
							end
						endcase
					end
				end
			end
			OP_AND, OP_OR: begin
				if (b_q != 4'd0 && !aok_q) err = ERR_ADDR;
				else begin
					wr_en = 1'b1;
					if (op_q == OP_AND) wr_data = {31'd0, (x_q != 32'd0) && (val != 32'd0)};
					else wr_data = {31'd0, (x_q != 32'd0) || (val != 32'd0)};
				end
			end
			OP_NOT: begin
				if (a_q == 4'd0) begin
					if (!aok_q) err = ERR_ADDR;
					else begin
						wr_en   = (b_q == 4'd0);
						wr_data = {31'd0, nv};
						mem_we  = 1'b1;
						mem_wd  = {31'd0, (rdata_q == 32'd0)};
					end
				end else if (b_q == 4'd0) begin
					wr_en   = 1'b1;
					wr_data = {31'd0, nv};
				end
			end
			OP_CMP: begin
				if (b_q != 4'd0 && !aok_q) err = ERR_ADDR;
				else begin
					flag_we = 1'b1;
					if (x_q == val) flag_d = FLAG_EQ;
					else if ($signed(x_q) < $signed(val)) flag_d = FLAG_LT;
					else flag_d = FLAG_GT;
				end
			end
			OP_JMP: begin
				priority case (b_q)
					JC_ALWAYS: taken = 1'b1;
					JC_EQ:     taken = (flag_q == FLAG_EQ);
					JC_GT:     taken = (flag_q == FLAG_GT);
					JC_LT:     taken = (flag_q == FLAG_LT);
					default:   taken = 1'b0;
				endcase
			end
			OP_IN: begin
				wr_en   = 1'b1;
				wr_data = inv_q;
			end
			default: ;
		endcase
	end

	// Divider step.
	logic [32:0] dv_tmp;
	logic        dv_ge;
	assign dv_tmp = {rem_q[31:0], quo_q[31]};
	assign dv_ge  = (dv_tmp >= {1'b0, dsr_q});

	assign st.div_go   = div_go;
	assign st.clr_last = (clr_cnt_q == AW'(DATA_WORDS - 1));
	assign st.res_free = !res_vld_q || result_ready;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= opcode;
			a_q   <= first_reg;
			b_q   <= second_reg;
			imm_q <= immediate;
			pc_q  <= pc_in;
			inv_q <= input_value;
			x_q   <= rf_rd;
		end
		if (cmd.read_b) y_q <= rf_rd;
		if (cmd.calc_addr) begin
			addr_q <= qa[AW-1:0];
			aok_q  <= !qa[32] && (qa < LIMIT);
		end
		if (cmd.exec) begin
			t_val_q  <= (op_q == OP_OUT) ? x_q : 32'd0;
			t_ov_q   <= (op_q == OP_OUT);
			t_halt_q <= (op_q == OP_STOP);
			t_err_q  <= err;
			t_tk_q   <= taken;
			t_npc_q  <= taken ? (pc_q + imm_q[15:0] - 16'd4) : pc_q;
			quo_q    <= x_q[31] ? (32'd0 - x_q) : x_q;
			dsr_q    <= val[31] ? (32'd0 - val) : val;
			rem_q    <= 33'd0;
			neg_q    <= x_q[31] ^ val[31];
		end else if (cmd.div_step) begin
			rem_q <= dv_ge ? (dv_tmp - {1'b0, dsr_q}) : dv_tmp;
			quo_q <= {quo_q[30:0], dv_ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) mem_q[clr_cnt_q] <= 32'd0;
		else if (cmd.exec && mem_we) mem_q[addr_q] <= mem_wd;
		if (cmd.mem_read) rdata_q <= mem_q[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) rf_q[i] <= 32'd0;
			flag_q    <= FLAG_EQ;
			clr_cnt_q <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (cmd.clr) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.exec && wr_en && a_q < 4'(NUM_REGS)) rf_q[a_q] <= wr_data;
			else if (cmd.div_wb && a_q < 4'(NUM_REGS))
				rf_q[a_q] <= neg_q ? (32'd0 - quo_q) : quo_q;
			if (cmd.exec && flag_we) flag_q <= flag_d;
			if (cmd.out_load) res_vld_q <= 1'b1;
			else if (result_ready) res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_value      <= t_val_q;
			out_valid      <= t_ov_q;
			halted         <= t_halt_q;
			error_code     <= t_err_q;
			branch_taken   <= t_tk_q;
			next_pc        <= t_npc_q;
			compare_result <= flag_q;
		end
	end

	assign result_valid = res_vld_q;

endmodule

// ----- hdl/toy_cpu_execute_unit.sv -----
// Top level of the execute unit: configuration port, controller and datapath.
// Depends on tcpu_pkg, tcpu_ctrl and tcpu_dpath.

// An item is one decoded instruction, and one item is in work at a time. A divide runs
// through a 32-step restoring divider before its result appears. The next item can be
// accepted once the result appears, while a result that waits for the receiver holds
// back the result of the next item until it is taken. After reset the unit clears its
// data memory one word a cycle and accepts no item until every word is cleared.
module toy_cpu_execute_unit #(
	parameter int DATA_WORDS = tcpu_pkg::DATA_WORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [3:0]         opcode,
	input  logic [3:0]         first_reg,
	input  logic [3:0]         second_reg,
	input  logic signed [31:0] immediate,
	input  logic [15:0]        pc_in,
	input  logic signed [31:0] input_value,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [31:0] out_value,
	output logic               out_valid,
	output logic               halted,
	output logic [1:0]         error_code,
	output logic               branch_taken,
	output logic [15:0]        next_pc,
	output logic signed [1:0]  compare_result
);
	import tcpu_pkg::*;

	logic [15:0] data_base_q;
	cmd_t        cmd;
	status_t     st;

	assign pready = 1'b1;
	// The only register occupies the whole address space of the port.
	assign prdata = paddr[1] ? {16'd0, data_base_q} : {16'd0, data_base_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_base_q <= DEFAULT_BASE;
		end else if (psel && penable && pwrite && pready) begin
			data_base_q <= pwdata[15:0];
		end
	end

	tcpu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.st         (st),
		.cmd        (cmd)
	);

	tcpu_dpath #(
		.DATA_WORDS (DATA_WORDS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.data_base      (data_base_q),
		.opcode         (opcode),
		.first_reg      (first_reg),
		.second_reg     (second_reg),
		.immediate      (immediate),
		.pc_in          (pc_in),
		.input_value    (input_value),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.out_value      (out_value),
		.out_valid      (out_valid),
		.halted         (halted),
		.error_code     (error_code),
		.branch_taken   (branch_taken),
		.next_pc        (next_pc),
		.compare_result (compare_result)
	);

endmodule

// ----- hdl/tcpu_checker.sv -----
// Port-level checker of the execute unit and its bind to the top level.
// Depends on tcpu_pkg and toy_cpu_execute_unit_defines.svh.
`include "toy_cpu_execute_unit_defines.svh"

module tcpu_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input logic signed [31:0] out_value,
	input logic              out_valid,
	input logic              halted,
	input logic [1:0]        error_code,
	input logic              branch_taken,
	input logic signed [1:0] compare_result
);
	import tcpu_pkg::*;

	`TCPU_ASSERT_NEXT(a_res_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(out_value) && $stable(error_code), "result item changed while stalled")
	`TCPU_ASSERT_NOW(a_one_kind, clk, arst_n, result_valid, $onehot0({out_valid, halted, branch_taken, error_code != ERR_NONE}), "result item reports more than one event")
	`TCPU_ASSERT_NOW(a_err_code, clk, arst_n, result_valid, error_code != 2'd3, "undefined error code")
	`TCPU_ASSERT_NOW(a_flag_code, clk, arst_n, result_valid, compare_result != 2'sb10, "undefined compare flag")
	`TCPU_ASSERT_NEXT(a_one_item, clk, arst_n, item_valid && item_ready, !item_ready, "second item taken while one is in work")

endmodule

bind toy_cpu_execute_unit tcpu_checker u_tcpu_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item_valid),
	.item_ready     (item_ready),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.out_value      (out_value),
	.out_valid      (out_valid),
	.halted         (halted),
	.error_code     (error_code),
	.branch_taken   (branch_taken),
	.compare_result (compare_result)
);

// ----- bench/tb_toy_cpu_execute_unit.sv -----
// Self-checking testbench of toy_cpu_execute_unit: random and directed
// instructions against a behavioural predictor held in a scoreboard class.
// Depends on tcpu_pkg and the RTL of the execute unit.
`timescale 1ns / 100ps

module tb_toy_cpu_execute_unit;
	import tcpu_pkg::*;

	localparam int WORDS = DATA_WORDS_DEF;
	localparam int SETTLE = 45;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [1:0] REG_DATA_BASE = 2'd0;

	typedef struct {
		logic [3:0]  op;
		logic [3:0]  ra;
		logic [3:0]  rb;
		logic [31:0] imm;
		logic [15:0] pc;
		logic [31:0] inv;
	} instr_t;

	typedef struct {
		logic [31:0] value;
		logic        vld;
		logic        stop;
		logic [1:0]  err;
		logic        taken;
		logic [15:0] npc;
		logic [1:0]  flag;
	} outcome_t;

	class exec_scoreboard;
		logic [31:0] regs [NUM_REGS];
		logic [31:0] mem [WORDS];
		logic [1:0]  flag;
		logic [15:0] base;
		outcome_t    expected_q [$];
		int          errors;

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (mem[i]) mem[i] = '0;
			flag = FLAG_EQ;
			base = DEFAULT_BASE;
			errors = 0;
		endfunction

		function logic [31:0] rd(logic [3:0] i);
			return (i < NUM_REGS) ? regs[i] : '0;
		endfunction

		function void wr(logic [3:0] i, logic [31:0] v);
			if (i < NUM_REGS)
				regs[i] = v;
		endfunction

		function bit map_addr(logic [31:0] r, output int idx);
			longint q;
			q = (longint'($signed(r)) - longint'(base)) / 2;
			idx = int'(q);
			return (q >= 0 && q < WORDS);
		endfunction

		function logic [1:0] operand(logic [3:0] b, logic [31:0] imm, output logic [31:0] v);
			int idx;
			v = imm;
			if (b == 0)
				return ERR_NONE;
			if (!map_addr(rd(b), idx))
				return ERR_ADDR;
			v = mem[idx];
			return ERR_NONE;
		endfunction

		function void note_item(instr_t it);
			outcome_t o;
			logic [31:0] x, v, nv, ar;
			int idx;
			longint sa, sb;
			o = '{value: '0, vld: 0, stop: 0, err: ERR_NONE, taken: 0, npc: it.pc, flag: '0};
			x = rd(it.ra);
			case (it.op)
				OP_STOP: o.stop = 1;
				OP_MOV: begin
					if (it.rb == 0) begin
						wr(it.ra, it.imm);
					end else if (it.ra inside {[1:4]} && it.rb inside {[5:8]}) begin
						if (map_addr(rd(it.rb), idx)) wr(it.ra, mem[idx]);
						else o.err = ERR_ADDR;
					end else if (it.ra inside {[5:8]} && it.rb inside {[1:4]}) begin
						if (map_addr(x, idx)) mem[idx] = rd(it.rb);
						else o.err = ERR_ADDR;
					end
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
					if (!(it.rb != 0 && it.rb < 5)) begin
						o.err = operand(it.rb, it.imm, v);
						if (o.err == ERR_NONE) begin
							case (it.op)
								OP_ADD: wr(it.ra, x + v);
								OP_SUB: wr(it.ra, x - v);
								OP_MUL: wr(it.ra, x * v);
								default: begin
									if (v == 0) o.err = ERR_DIV0;
									else wr(it.ra, 32'(longint'($signed(x)) /
										longint'($signed(v))));
								end
							endcase
						end
					end
				end
				OP_AND, OP_OR: begin
					o.err = operand(it.rb, it.imm, v);
					if (o.err == ERR_NONE) begin
						if (it.op == OP_AND) wr(it.ra, 32'((x != 0) && (v != 0)));
						else wr(it.ra, 32'((x != 0) || (v != 0)));
					end
				end
				OP_NOT: begin
					nv = 32'(x == 0);
					if (it.ra == 0) begin
						ar = (it.rb == 0) ? nv : rd(it.rb);
						if (!map_addr(ar, idx)) begin
							o.err = ERR_ADDR;
						end else begin
							if (it.rb == 0) wr(it.ra, nv);
							mem[idx] = 32'(mem[idx] == 0);
						end
					end else if (it.rb == 0) begin
						wr(it.ra, nv);
					end
				end
				OP_CMP: begin
					o.err = operand(it.rb, it.imm, v);
					if (o.err == ERR_NONE) begin
						sa = longint'($signed(x));
						sb = longint'($signed(v));
						flag = (sa == sb) ? FLAG_EQ : ((sa < sb) ? FLAG_LT : FLAG_GT);
					end
				end
				OP_JMP: begin
					case (it.rb)
						JC_ALWAYS: o.taken = 1;
						JC_EQ: o.taken = (flag == FLAG_EQ);
						JC_GT: o.taken = (flag == FLAG_GT);
						JC_LT: o.taken = (flag == FLAG_LT);
						default: o.taken = 0;
					endcase
					if (o.taken)
						o.npc = 16'(32'(it.pc) + it.imm - 32'd4);
				end
				OP_IN: wr(it.ra, it.inv);
				OP_OUT: begin
					o.value = x;
					o.vld = 1;
				end
				default: ;
			endcase
			o.flag = flag;
			expected_q.push_back(o);
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
			errors++;
		endtask

		task check_result(outcome_t got);
			outcome_t w;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result, value", got.value, '0);
			end else begin
				w = expected_q.pop_front();
				if (got.value !== w.value) report_mismatch("out_value", got.value, w.value);
				if (got.vld !== w.vld) report_mismatch("out_valid", got.vld, w.vld);
				if (got.stop !== w.stop) report_mismatch("halted", got.stop, w.stop);
				if (got.err !== w.err) report_mismatch("error_code", got.err, w.err);
				if (got.taken !== w.taken) report_mismatch("branch_taken", got.taken, w.taken);
				if (got.npc !== w.npc) report_mismatch("next_pc", got.npc, w.npc);
				if (got.flag !== w.flag) report_mismatch("compare_result", got.flag, w.flag);
			end
		endtask
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic item_valid, item_ready, result_valid, result_ready;
	logic [3:0] opcode, first_reg, second_reg;
	logic signed [31:0] immediate, input_value, out_value;
	logic [15:0] pc_in, next_pc;
	logic out_valid, halted, branch_taken;
	logic [1:0] error_code;
	logic signed [1:0] compare_result;

	exec_scoreboard sb;
	int send_idle_pct, recv_stall_pct, cycles;

	toy_cpu_execute_unit DUT (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_toy_cpu_execute_unit: errors");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n)
			result_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready)
			sb.note_item('{opcode, first_reg, second_reg, immediate, pc_in, input_value});
		if (arst_n && result_valid && result_ready)
			sb.check_result('{out_value, out_valid, halted, error_code, branch_taken,
				next_pc, compare_result});
	end

	task write_base(logic [15:0] v);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= REG_DATA_BASE;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		sb.base = v;
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task wait_drained();
		do
			@(posedge clk);
		while (sb.expected_q.size() != 0);
	endtask

	task send_item(instr_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 0;
			@(posedge clk);
		end
		opcode <= it.op;
		first_reg <= it.ra;
		second_reg <= it.rb;
		immediate <= it.imm;
		pc_in <= it.pc;
		input_value <= it.inv;
		item_valid <= 1;
		do
			@(posedge clk);
		while (!item_ready);
	endtask

	function instr_t mk(logic [3:0] op, logic [3:0] ra, logic [3:0] rb, logic [31:0] imm);
		return '{op, ra, rb, imm, 16'($urandom), $urandom};
	endfunction

	function logic [31:0] pick_imm();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($urandom_range(3)) - 32'd1;
			3: return 32'($urandom_range(15));
			default: return $urandom;
		endcase
	endfunction

	function instr_t random_item();
		instr_t it;
		int r, k;
		it = mk(4'($urandom_range(OP_OUT)), 4'($urandom_range(8)), 4'd0, pick_imm());
		r = $urandom_range(99);
		if (r < 18) begin
			case ($urandom_range(9))
				0: k = 4094 + $urandom_range(3);
				1: k = -1 - $urandom_range(2);
				default: k = $urandom_range(31);
			endcase
			it.op = OP_MOV;
			it.ra = 4'($urandom_range(1, 8));
			it.imm = 32'(sb.base) + 32'(2 * k) + 32'($urandom_range(1));
		end else if (r < 88) begin
			if (it.op == OP_MOV && $urandom_range(1)) begin
				if ($urandom_range(1)) begin
					it.ra = 4'($urandom_range(1, 4));
					it.rb = 4'($urandom_range(5, 8));
				end else begin
					it.ra = 4'($urandom_range(5, 8));
					it.rb = 4'($urandom_range(1, 4));
				end
			end else if ($urandom_range(1)) begin
				it.rb = (it.op == OP_JMP) ? 4'($urandom_range(4)) : 4'($urandom_range(1, 8));
			end
			if (it.op == OP_DIV && $urandom_range(3) == 0)
				it.imm = '0;
		end else begin
			it = '{4'($urandom), 4'($urandom), 4'($urandom), $urandom,
				16'($urandom), $urandom};
		end
		return it;
	endfunction

	task run_random(int n, int idle, int stall, bit hold_off);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			if (hold_off && i % 150 == 75) begin
				item_valid <= 0;
				wait_drained();
			end
			send_item(random_item());
		end
		item_valid <= 0;
		wait_drained();
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		instr_t directed [$];
		sb = new();
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		item_valid = 0;
		result_ready = 0;
		opcode = '0;
		first_reg = '0;
		second_reg = '0;
		immediate = '0;
		pc_in = '0;
		input_value = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		write_base(DEFAULT_BASE);

		directed = '{
			mk(OP_MOV, 5, 0, 32'(DEFAULT_BASE)),
			'{OP_IN, 4'd2, 4'd0, 32'd0, 16'h0000, 32'h7FFF_FFFF},
			mk(OP_MOV, 5, 2, 0), mk(OP_MOV, 3, 5, 0), mk(OP_ADD, 3, 5, 0),
			mk(OP_SUB, 3, 0, 32'h8000_0000), mk(OP_MUL, 3, 0, 32'hFFFF_FFFF),
			mk(OP_DIV, 3, 0, 0), mk(OP_MOV, 1, 0, 32'h8000_0000),
			mk(OP_DIV, 1, 0, 32'hFFFF_FFFF), mk(OP_AND, 4, 5, 0), mk(OP_OR, 4, 0, 0),
			mk(OP_NOT, 4, 0, 0), mk(OP_NOT, 0, 5, 0), mk(OP_NOT, 0, 0, 0),
			mk(OP_CMP, 3, 5, 0),
			'{OP_JMP, 4'd0, JC_EQ, 32'd7, 16'hFFFF, 32'h8000_0000},
			mk(OP_JMP, 0, JC_GT, 9), mk(OP_JMP, 0, JC_LT, 32'hFFFF_FF9C),
			mk(OP_JMP, 0, 9, 5), mk(OP_MOV, 6, 0, 0), mk(OP_DIV, 1, 6, 0),
			mk(OP_OUT, 3, 0, 0), mk(4'd13, 15, 15, 0), mk(OP_IN, 12, 0, 0),
			mk(OP_OUT, 9, 0, 0), mk(OP_STOP, 0, 0, 0)
		};
		recv_stall_pct = 30;
		foreach (directed[i])
			send_item(directed[i]);
		item_valid <= 0;
		wait_drained();
		repeat (SETTLE) @(posedge clk);

		run_random(560, 24, 55, 0);
		write_base(16'h0000);
		run_random(560, 55, 24, 1);
		write_base(16'hFFFF);
		run_random(290, 0, 0, 0);
		write_base(16'($urandom));
		run_random(290, 0, 0, 0);

		if (sb.errors == 0)
			$display("tb_toy_cpu_execute_unit: clean");
		else
			$display("tb_toy_cpu_execute_unit: errors");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/tcpu_pkg.sv
hdl/tcpu_ctrl.sv
hdl/tcpu_dpath.sv
hdl/toy_cpu_execute_unit.sv
hdl/tcpu_checker.sv
bench/tb_toy_cpu_execute_unit.sv
